### rtl/core/mi3_pkg.sv
package mi3_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam int N_ELEM = 9;

    // Each cofactor is elem[a] * elem[b] - elem[c] * elem[d].
    localparam int unsigned COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

    // Cofactors that meet row 0 in the determinant expansion.
    localparam int unsigned DET_COF [3] = '{0, 3, 6};

    typedef struct packed {
        logic valid;
        logic zero;
        logic neg;
    } det_ctl_t;

    typedef struct packed {
        logic valid;
        logic singular;
        logic overflowed;
    } res_ctl_t;

endpackage

### rtl/core/matrix_inverse_3x3_unit.sv
// Inverts one 3x3 matrix of signed fixed-point elements per transfer.
// The slave channel takes the nine elements in s_tdata, row by row, each
// WORD_BITS wide with FRAC_BITS fraction bits. The master channel returns the
// nine inverse elements in the same format in m_tdata, with the singular and
// overflow flags in m_tuser.
// The determinant and cofactors are formed exactly and each element is divided
// once, rounded to nearest with ties away from zero and saturated to the word.
// A singular matrix gives all-zero elements with the singular flag set.
// An input transfer goes through the cofactor and determinant pipeline and then
// the restoring divider, with one quotient bit per stage, until it is offered.
// One matrix is accepted in every cycle while s_tready is high; the pipeline
// holds no state between matrices.
// Reset empties the pipeline and the output buffer; no result is offered
// until a new matrix has been taken.
// When the receiver stalls, a two-entry output buffer absorbs the item in
// flight; s_tready then drops and the whole pipeline holds until the receiver
// takes the waiting result, so nothing is lost or repeated.
module matrix_inverse_3x3_unit
    import mi3_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int DATA_BITS = ((N_ELEM * WORD_BITS + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // in_r0c0, in_r0c1, ... in_r2c2, then zero padding
    input  logic [DATA_BITS-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // inv_r0c0, inv_r0c1, ... inv_r2c2, then zero padding
    output logic [DATA_BITS-1:0] m_tdata,
    // singular, overflowed
    output logic [1:0]           m_tuser
);

    localparam int CW = 2 * WORD_BITS + 1;
    localparam int DW = 3 * WORD_BITS + 3;
    localparam int PAY_BITS = DATA_BITS + 2;

    logic                  en;
    det_ctl_t              det_ctl;
    logic [DW-1:0]         dmag;
    logic [CW-1:0]         cof_mag [N_ELEM];
    logic [N_ELEM-1:0]     cof_neg;
    res_ctl_t              res;
    logic [WORD_BITS-1:0]  inv [N_ELEM];
    logic [DATA_BITS-1:0]  res_data;
    logic [PAY_BITS-1:0]   out_pay;

    assign s_tready = en;

    mi3_det #(
        .WORD_BITS (WORD_BITS)
    ) u_det (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid & en),
        .elem     (s_tdata[N_ELEM*WORD_BITS-1:0]),
        .ctl      (det_ctl),
        .dmag     (dmag),
        .cof_mag  (cof_mag),
        .cof_neg  (cof_neg)
    );

    mi3_div #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (det_ctl),
        .dmag    (dmag),
        .cof_mag (cof_mag),
        .cof_neg (cof_neg),
        .res     (res),
        .inv     (inv)
    );

    always_comb
    begin
        res_data = '0;
        for (int k = 0; k < N_ELEM; k++)
        begin
            res_data[k*WORD_BITS +: WORD_BITS] = inv[k];
        end
    end

    mi3_skid #(
        .PAY_BITS (PAY_BITS)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res.valid),
        .in_data   ({res.overflowed, res.singular, res_data}),
        .en        (en),
        .out_valid (m_tvalid),
        .out_data  (out_pay),
        .out_ready (m_tready)
    );

    assign m_tdata = out_pay[DATA_BITS-1:0];
    assign m_tuser = out_pay[PAY_BITS-1:DATA_BITS];

endmodule

### rtl/core/mi3_det.sv
module mi3_det
    import mi3_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    localparam int CW = 2 * WORD_BITS + 1,
    localparam int DW = 3 * WORD_BITS + 3
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [N_ELEM*WORD_BITS-1:0]   elem,
    output det_ctl_t                      ctl,
    output logic [DW-1:0]                 dmag,
    output logic [CW-1:0]                 cof_mag [N_ELEM],
    output logic [N_ELEM-1:0]             cof_neg
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam int TW = 3 * W + 1;

    logic signed [W-1:0]  m [N_ELEM];

    logic [5:0]           vld_reg;
    logic signed [PW-1:0] prod_reg [N_ELEM][2];
    logic signed [W-1:0]  r0a_reg [3];
    logic signed [W-1:0]  r0b_reg [3];
    logic signed [CW-1:0] cof_b_reg [N_ELEM];
    logic signed [CW-1:0] cof_c_reg [N_ELEM];
    logic signed [CW-1:0] cof_d_reg [N_ELEM];
    logic signed [CW-1:0] cof_e_reg [N_ELEM];
    logic signed [W:0]    lo_op [3];
    logic signed [W:0]    hi_op [3];
    logic signed [PW:0]   pl_reg [3];
    logic signed [PW:0]   ph_reg [3];
    logic signed [TW-1:0] term_reg [3];
    logic signed [DW-1:0] det_reg;
    logic [DW-1:0]        dmag_reg;
    logic                 zero_reg;
    logic                 neg_reg;
    logic [CW-1:0]        cof_mag_reg [N_ELEM];
    logic [N_ELEM-1:0]    cof_neg_reg;

    genvar gi;
    generate
        for (gi = 0; gi < N_ELEM; gi++) begin : g_elem
            assign m[gi] = elem[gi*W +: W];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            lo_op[j] = $signed({1'b0, cof_b_reg[DET_COF[j]][W-1:0]});
            hi_op[j] = cof_b_reg[DET_COF[j]][CW-1:W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                prod_reg[k][0] <= m[COF_IDX[k][0]] * m[COF_IDX[k][1]];
                prod_reg[k][1] <= m[COF_IDX[k][2]] * m[COF_IDX[k][3]];
                cof_b_reg[k]   <= CW'(prod_reg[k][0]) - CW'(prod_reg[k][1]);
                cof_c_reg[k]   <= cof_b_reg[k];
                cof_d_reg[k]   <= cof_c_reg[k];
                cof_e_reg[k]   <= cof_d_reg[k];
                cof_mag_reg[k] <= cof_e_reg[k][CW-1] ? CW'(-cof_e_reg[k]) : CW'(cof_e_reg[k]);
                cof_neg_reg[k] <= cof_e_reg[k][CW-1];
            end
            for (int j = 0; j < 3; j++)
            begin
                r0a_reg[j]  <= m[j];
                r0b_reg[j]  <= r0a_reg[j];
                pl_reg[j]   <= lo_op[j] * r0b_reg[j];
                ph_reg[j]   <= hi_op[j] * r0b_reg[j];
                term_reg[j] <= (TW'(ph_reg[j]) <<< W) + TW'(pl_reg[j]);
            end
            det_reg  <= DW'(term_reg[0]) + DW'(term_reg[1]) + DW'(term_reg[2]);
            dmag_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            zero_reg <= (det_reg == '0);
            neg_reg  <= det_reg[DW-1];
        end
    end

    assign ctl.valid = vld_reg[5];
    assign ctl.zero  = zero_reg;
    assign ctl.neg   = neg_reg;
    assign dmag      = dmag_reg;
    assign cof_mag   = cof_mag_reg;
    assign cof_neg   = cof_neg_reg;

endmodule

### rtl/core/mi3_div.sv
module mi3_div
    import mi3_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int CW = 2 * WORD_BITS + 1,
    localparam int DW = 3 * WORD_BITS + 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  det_ctl_t             ctl_in,
    input  logic [DW-1:0]        dmag,
    input  logic [CW-1:0]        cof_mag [N_ELEM],
    input  logic [N_ELEM-1:0]    cof_neg,
    output res_ctl_t             res,
    output logic [WORD_BITS-1:0] inv [N_ELEM]
);

    localparam int W  = WORD_BITS;
    localparam int NW = CW + 2 * FRAC_BITS;
    localparam int SW = DW + W;
    localparam int XW = ((NW > SW) ? NW : SW) + 1;

    logic [W+2:0]      vld_reg;
    logic [XW-1:0]     rem_reg  [0:W][N_ELEM];
    logic [W-1:0]      q_reg    [0:W][N_ELEM];
    logic [N_ELEM-1:0] neg_reg  [0:W];
    logic [N_ELEM-1:0] big_reg  [0:W];
    logic [DW-1:0]     d_reg    [0:W];
    logic              zero_reg [0:W];

    logic [W:0]        qr_reg [N_ELEM];
    logic [N_ELEM-1:0] rneg_reg;
    logic [N_ELEM-1:0] rbig_reg;
    logic              rzero_reg;

    logic [W-1:0]      inv_reg [N_ELEM];
    logic              sing_reg;
    logic              ovf_reg;

    logic [XW-1:0]     num [N_ELEM];
    logic [DW:0]       rem2 [N_ELEM];
    logic [N_ELEM-1:0] rup;
    logic [W:0]        limit [N_ELEM];
    logic [N_ELEM-1:0] sat;
    logic [W:0]        clip [N_ELEM];
    logic [W-1:0]      inv_next [N_ELEM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[W+1:0], ctl_in.valid};
        end
    end

    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
        begin
            num[k] = XW'(cof_mag[k]) << (2 * FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                rem_reg[0][k] <= num[k];
                q_reg[0][k]   <= '0;
                big_reg[0][k] <= (num[k] >= (XW'(dmag) << W));
                neg_reg[0][k] <= cof_neg[k] ^ ctl_in.neg;
            end
            d_reg[0]    <= dmag;
            zero_reg[0] <= ctl_in.zero;
        end
    end

    genvar gs;
    generate
        for (gs = 1; gs <= W; gs++) begin : g_stage
            localparam int BIT = W - gs;
            logic [XW:0]  diff   [N_ELEM];
            logic [W-1:0] q_next [N_ELEM];

            always_comb
            begin
                for (int k = 0; k < N_ELEM; k++)
                begin
                    diff[k]        = {1'b0, rem_reg[gs-1][k]}
                                     - ((XW+1)'(d_reg[gs-1]) << BIT);
                    q_next[k]      = q_reg[gs-1][k];
                    q_next[k][BIT] = ~diff[k][XW];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int k = 0; k < N_ELEM; k++)
                    begin
                        rem_reg[gs][k] <= diff[k][XW] ? rem_reg[gs-1][k] : diff[k][XW-1:0];
                        q_reg[gs][k]   <= q_next[k];
                    end
                    neg_reg[gs]  <= neg_reg[gs-1];
                    big_reg[gs]  <= big_reg[gs-1];
                    d_reg[gs]    <= d_reg[gs-1];
                    zero_reg[gs] <= zero_reg[gs-1];
                end
            end
        end
    endgenerate

    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
        begin
            rem2[k] = {rem_reg[W][k][DW-1:0], 1'b0};
            rup[k]  = (rem2[k] >= (DW+1)'(d_reg[W]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                qr_reg[k] <= {1'b0, q_reg[W][k]} + (W+1)'(rup[k]);
            end
            rneg_reg  <= neg_reg[W];
            rbig_reg  <= big_reg[W];
            rzero_reg <= zero_reg[W];
        end
    end

    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
        begin
            limit[k] = rneg_reg[k] ? ((W+1)'(1) << (W - 1))
                                   : (((W+1)'(1) << (W - 1)) - (W+1)'(1));
            sat[k]   = rbig_reg[k] | (qr_reg[k] > limit[k]);
            clip[k]  = sat[k] ? limit[k] : qr_reg[k];
            if (rzero_reg)
            begin
                inv_next[k] = '0;
            end
            else if (rneg_reg[k])
            begin
                inv_next[k] = -clip[k][W-1:0];
            end
            else
            begin
                inv_next[k] = clip[k][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg  <= inv_next;
            sing_reg <= rzero_reg;
            ovf_reg  <= (|sat) & ~rzero_reg;
        end
    end

    assign res.valid      = vld_reg[W+2];
    assign res.singular   = sing_reg;
    assign res.overflowed = ovf_reg;
    assign inv            = inv_reg;

endmodule

### rtl/core/mi3_skid.sv
module mi3_skid
    import mi3_pkg::*;
#(
    parameter int PAY_BITS = 2 * WORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [PAY_BITS-1:0] in_data,
    output logic                en,
    output logic                out_valid,
    output logic [PAY_BITS-1:0] out_data,
    input  logic                out_ready
);

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                spare_valid_reg;
    logic                spare_valid_next;
    logic [PAY_BITS-1:0] out_data_reg;
    logic [PAY_BITS-1:0] out_data_next;
    logic [PAY_BITS-1:0] spare_data_reg;
    logic [PAY_BITS-1:0] spare_data_next;
    logic                take;

    assign take = out_valid_reg & out_ready;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        spare_valid_next = spare_valid_reg;
        out_data_next    = out_data_reg;
        spare_data_next  = spare_data_reg;
        if (spare_valid_reg)
        begin
            if (take)
            begin
                out_data_next    = spare_data_reg;
                spare_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_next = in_valid;
            out_data_next  = in_data;
        end
        else if (in_valid)
        begin
            spare_valid_next = 1'b1;
            spare_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        spare_data_reg <= spare_data_next;
    end

    assign en        = ~spare_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/core/mi3_checker.sv
module mi3_checker
    import mi3_pkg::*;
#(
    parameter int DATA_BITS = ((N_ELEM * WORD_BITS_DEF + 7) / 8) * 8
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [DATA_BITS-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    // A stalled result transfer keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A singular matrix yields zero elements and no overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("singular result not cleared");

    // The input side only closes after the output side has stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input closed without an output stall");

    // Reset leaves nothing on offer.
    assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

endmodule

bind matrix_inverse_3x3_unit mi3_checker #(.DATA_BITS(DATA_BITS)) u_mi3_checker (.*);
